@@ hw/rtl/esort_pkg.sv @@
`default_nettype none
package esort_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int LABEL_W   = 32;
	localparam int ENERGY_W  = 64;
	localparam int MOM_W     = 32;
	localparam int SPIN_W    = 8;
	localparam int TOL_W     = 63;
	localparam logic [TOL_W-1:0] TOL_RESET = 63'd110;

	typedef enum logic [4:0] {
		ST_IDLE, ST_INIT, ST_NODE, ST_M_RD, ST_M_CMP, ST_C_RD, ST_C_WR,
		ST_P_BRD, ST_P_BASE, ST_P_RD, ST_P_DIF, ST_P_CMP, ST_P_SW1, ST_P_SW2,
		ST_E_RD, ST_E_REC, ST_E_OUT
	} state_t;

	// which part of a sort segment is still to do
	typedef enum logic [1:0] {
		PH_LEFT, PH_RIGHT, PH_MERGE
	} phase_t;

	typedef struct packed {
		logic load;
		logic init;
		logic node;
		logic mrg_rd;
		logic mrg_cmp;
		logic cp_rd;
		logic cp_wr;
		logic p_brd;
		logic p_base;
		logic p_rd;
		logic p_dif;
		logic p_cmp;
		logic p_sw1;
		logic p_sw2;
		logic em_rd;
		logic em_rec;
		logic em_out;
	} cmd_t;

	typedef struct packed {
		logic node_merge;
		logic child_leaf;
		logic stack_empty;
		logic mrg_last;
		logic copy_last;
		logic scan_stop;
		logic scan_end;
		logic pass_end;
		logic emit_last;
	} sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/eigenstate_energy_spin_sort.sv @@
// channel   | handshake                  | payload
// ----------+----------------------------+---------------------------------------------
// record in | start & !busy              | state_label energy momentum_x/y spin_twice
//           |                            | last_record
// config    | cfg_we                     | cfg_wdata (energy_tolerance, Q23.40)
// result    | result_strobe (1 cycle)    | sorted_* fields, final_record
//
// Records load one word per cycle into the record store while busy is low.
// A word with last_record starts the sort: merge sort driven by a segment
// stack, each element of a tree level read from both entry RAM copies,
// compared, then copied back; then the spin pass, which scans entries for
// each position; then emission, one result after another.
// Reset clears the state machine, record count and stack pointer and sets the tolerance to its default.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module eigenstate_energy_spin_sort #(
	parameter int DEPTH = esort_pkg::DEPTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic [esort_pkg::LABEL_W-1:0]          state_label,
	input  wire logic signed [esort_pkg::ENERGY_W-1:0]  energy,
	input  wire logic signed [esort_pkg::MOM_W-1:0]     momentum_x,
	input  wire logic signed [esort_pkg::MOM_W-1:0]     momentum_y,
	input  wire logic signed [esort_pkg::SPIN_W-1:0]    spin_twice,
	input  wire logic                                   last_record,
	input  wire logic                                   cfg_we,
	input  wire logic [esort_pkg::TOL_W-1:0]            cfg_wdata,
	output logic                                        result_strobe,
	output logic [esort_pkg::LABEL_W-1:0]               sorted_label,
	output logic signed [esort_pkg::ENERGY_W-1:0]       sorted_energy,
	output logic signed [esort_pkg::MOM_W-1:0]          sorted_momentum_x,
	output logic signed [esort_pkg::MOM_W-1:0]          sorted_momentum_y,
	output logic signed [esort_pkg::SPIN_W-1:0]         sorted_spin_twice,
	output logic                                        final_record
);

	// controller issues one command per state; datapath reports compare results
	esort_pkg::cmd_t cmd;
	esort_pkg::sts_t sts;

	esort_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.last_record   (last_record),
		.sts           (sts),
		.cmd           (cmd),
		.busy          (busy),
		.result_strobe (result_strobe)
	);

	esort_dp #(.DEPTH(DEPTH)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.state_label       (state_label),
		.energy            (energy),
		.momentum_x        (momentum_x),
		.momentum_y        (momentum_y),
		.spin_twice        (spin_twice),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.sorted_label      (sorted_label),
		.sorted_energy     (sorted_energy),
		.sorted_momentum_x (sorted_momentum_x),
		.sorted_momentum_y (sorted_momentum_y),
		.sorted_spin_twice (sorted_spin_twice),
		.final_record      (final_record)
	);

endmodule
`default_nettype wire

@@ hw/rtl/esort_ram.sv @@
`default_nettype none
module esort_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ hw/rtl/esort_ctrl.sv @@
`default_nettype none
module esort_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            last_record,
	input  wire esort_pkg::sts_t sts,
	output esort_pkg::cmd_t      cmd,
	output logic                 busy,
	output logic                 result_strobe
);

	esort_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= esort_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			esort_pkg::ST_IDLE: begin
				if (start && last_record) state_nxt = esort_pkg::ST_INIT;
			end
			esort_pkg::ST_INIT:   state_nxt = esort_pkg::ST_NODE;
			esort_pkg::ST_NODE: begin
				if (sts.node_merge || sts.child_leaf) state_nxt = esort_pkg::ST_M_RD;
			end
			esort_pkg::ST_M_RD:   state_nxt = esort_pkg::ST_M_CMP;
			esort_pkg::ST_M_CMP: begin
				state_nxt = sts.mrg_last ? esort_pkg::ST_C_RD : esort_pkg::ST_M_RD;
			end
			esort_pkg::ST_C_RD:   state_nxt = esort_pkg::ST_C_WR;
			esort_pkg::ST_C_WR: begin
				if (!sts.copy_last) state_nxt = esort_pkg::ST_C_RD;
				else if (sts.stack_empty) state_nxt = esort_pkg::ST_P_BRD;
				else state_nxt = esort_pkg::ST_NODE;
			end
			esort_pkg::ST_P_BRD:  state_nxt = esort_pkg::ST_P_BASE;
			esort_pkg::ST_P_BASE: state_nxt = esort_pkg::ST_P_RD;
			esort_pkg::ST_P_RD:   state_nxt = esort_pkg::ST_P_DIF;
			esort_pkg::ST_P_DIF:  state_nxt = esort_pkg::ST_P_CMP;
			esort_pkg::ST_P_CMP: begin
				state_nxt = (sts.scan_stop || sts.scan_end) ? esort_pkg::ST_P_SW1
					: esort_pkg::ST_P_RD;
			end
			esort_pkg::ST_P_SW1:  state_nxt = esort_pkg::ST_P_SW2;
			esort_pkg::ST_P_SW2: begin
				state_nxt = sts.pass_end ? esort_pkg::ST_E_RD : esort_pkg::ST_P_BRD;
			end
			esort_pkg::ST_E_RD:   state_nxt = esort_pkg::ST_E_REC;
			esort_pkg::ST_E_REC:  state_nxt = esort_pkg::ST_E_OUT;
			esort_pkg::ST_E_OUT: begin
				state_nxt = sts.emit_last ? esort_pkg::ST_IDLE : esort_pkg::ST_E_RD;
			end
			default: state_nxt = esort_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		busy          = 1'b1;
		result_strobe = 1'b0;
		case (state_q)
			esort_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			esort_pkg::ST_INIT:   cmd.init    = 1'b1;
			esort_pkg::ST_NODE:   cmd.node    = 1'b1;
			esort_pkg::ST_M_RD:   cmd.mrg_rd  = 1'b1;
			esort_pkg::ST_M_CMP:  cmd.mrg_cmp = 1'b1;
			esort_pkg::ST_C_RD:   cmd.cp_rd   = 1'b1;
			esort_pkg::ST_C_WR:   cmd.cp_wr   = 1'b1;
			esort_pkg::ST_P_BRD:  cmd.p_brd   = 1'b1;
			esort_pkg::ST_P_BASE: cmd.p_base  = 1'b1;
			esort_pkg::ST_P_RD:   cmd.p_rd    = 1'b1;
			esort_pkg::ST_P_DIF:  cmd.p_dif   = 1'b1;
			esort_pkg::ST_P_CMP:  cmd.p_cmp   = 1'b1;
			esort_pkg::ST_P_SW1:  cmd.p_sw1   = 1'b1;
			esort_pkg::ST_P_SW2:  cmd.p_sw2   = 1'b1;
			esort_pkg::ST_E_RD:   cmd.em_rd   = 1'b1;
			esort_pkg::ST_E_REC:  cmd.em_rec  = 1'b1;
			esort_pkg::ST_E_OUT: begin
				cmd.em_out    = 1'b1;
				result_strobe = 1'b1;
			end
			default: busy = 1'b1;
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/esort_dp.sv @@
`default_nettype none
module esort_dp #(
	parameter int DEPTH = esort_pkg::DEPTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire esort_pkg::cmd_t                        cmd,
	output esort_pkg::sts_t                             sts,
	input  wire logic [esort_pkg::LABEL_W-1:0]          state_label,
	input  wire logic signed [esort_pkg::ENERGY_W-1:0]  energy,
	input  wire logic signed [esort_pkg::MOM_W-1:0]     momentum_x,
	input  wire logic signed [esort_pkg::MOM_W-1:0]     momentum_y,
	input  wire logic signed [esort_pkg::SPIN_W-1:0]    spin_twice,
	input  wire logic                                   cfg_we,
	input  wire logic [esort_pkg::TOL_W-1:0]            cfg_wdata,
	output logic [esort_pkg::LABEL_W-1:0]               sorted_label,
	output logic signed [esort_pkg::ENERGY_W-1:0]       sorted_energy,
	output logic signed [esort_pkg::MOM_W-1:0]          sorted_momentum_x,
	output logic signed [esort_pkg::MOM_W-1:0]          sorted_momentum_y,
	output logic signed [esort_pkg::SPIN_W-1:0]         sorted_spin_twice,
	output logic                                        final_record
);

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int SD  = AW + 1;
	localparam int TW  = $clog2(SD);
	localparam int SPW = $clog2(SD + 1);
	localparam int SW  = esort_pkg::SPIN_W;
	localparam int EGW = esort_pkg::ENERGY_W;
	localparam int E_LO = SW;
	localparam int E_HI = SW + EGW - 1;
	localparam int EW  = AW + EGW + SW;
	localparam int RW  = esort_pkg::LABEL_W + EGW + 2 * esort_pkg::MOM_W + SW;

	// sort entry: {record index, energy, spin}
	logic [CW-1:0] count_q, n_q;
	logic [esort_pkg::TOL_W-1:0] tol_q;
	logic [SPW-1:0] sp_q;

	logic [CW-1:0]     stk_lo_q [SD];
	logic [CW-1:0]     stk_m_q  [SD];
	esort_pkg::phase_t stk_ph_q [SD];

	logic [CW-1:0] mlo_q, mid_q, hi_q, i1_q, i2_q, k_q;
	logic          leaf_q;
	logic [CW-1:0] pi_q, pj_q, pk_q;
	logic [EW-1:0] rec_i_q, rec_k_q, ent_q;
	logic signed [SW-1:0]  best_q;
	logic signed [EGW-1:0] base_q;
	logic [EGW-1:0] mag_q;
	logic final_q;

	logic [EW-1:0] a0_rd, a1_rd, b_rd, a_wd;
	logic [RW-1:0] rec_rd;
	logic          a_we;
	logic [AW-1:0] a_wa, a0_ra;

	logic [TW-1:0] top;
	logic [CW-1:0] top_lo, top_m, half, child_lo, child_m;
	esort_pkg::phase_t top_ph;

	logic v1, v2, take_right;
	logic signed [EGW-1:0] e1, e2, ej;
	logic signed [SW-1:0]  s1, s2, sj;
	logic signed [EGW:0]   d_fwd, d_rev;

	assign top    = TW'(sp_q - 1'b1);
	assign top_lo = stk_lo_q[top];
	assign top_m  = stk_m_q[top];
	assign top_ph = stk_ph_q[top];
	assign half   = top_m >> 1;
	assign child_lo = (top_ph == esort_pkg::PH_LEFT) ? top_lo : CW'(top_lo + half);
	assign child_m  = (top_ph == esort_pkg::PH_LEFT) ? half : CW'(top_m - half);

	assign e1 = a0_rd[E_HI:E_LO];
	assign e2 = a1_rd[E_HI:E_LO];
	assign s1 = a0_rd[SW-1:0];
	assign s2 = a1_rd[SW-1:0];
	assign ej = a0_rd[E_HI:E_LO];
	assign sj = ent_q[SW-1:0];
	assign v1 = i1_q < mid_q;
	assign v2 = i2_q < hi_q;
	// leaves of two order on energy only; merges break energy ties on spin
	assign take_right = !v1 || (v2 && ((e1 > e2) || (!leaf_q && (e1 == e2) && (s1 > s2))));
	assign d_fwd = {ej[EGW-1], ej} - {base_q[EGW-1], base_q};
	assign d_rev = {base_q[EGW-1], base_q} - {ej[EGW-1], ej};

	assign sts.node_merge  = top_ph == esort_pkg::PH_MERGE;
	assign sts.child_leaf  = child_m == CW'(2);
	assign sts.stack_empty = sp_q == '0;
	assign sts.mrg_last    = CW'(k_q + 1'b1) == hi_q;
	assign sts.copy_last   = CW'(k_q + 1'b1) == hi_q;
	assign sts.scan_stop   = mag_q >= {1'b0, tol_q};
	assign sts.scan_end    = CW'(pj_q + 1'b1) == n_q;
	assign sts.pass_end    = CW'(pi_q + 1'b1) == n_q;
	assign sts.emit_last   = CW'(k_q + 1'b1) == n_q;

	always_comb begin
		a_we = 1'b0;
		a_wa = count_q[AW-1:0];
		a_wd = {count_q[AW-1:0], energy, spin_twice};
		if (cmd.load) begin
			a_we = count_q < CW'(DEPTH);
		end else if (cmd.cp_wr) begin
			a_we = 1'b1;
			a_wa = k_q[AW-1:0];
			a_wd = b_rd;
		end else if (cmd.p_sw1) begin
			a_we = 1'b1;
			a_wa = pk_q[AW-1:0];
			a_wd = rec_i_q;
		end else if (cmd.p_sw2) begin
			a_we = 1'b1;
			a_wa = pi_q[AW-1:0];
			a_wd = rec_k_q;
		end
	end

	always_comb begin
		a0_ra = i1_q[AW-1:0];
		if (cmd.p_brd) a0_ra = pi_q[AW-1:0];
		else if (cmd.p_rd) a0_ra = pj_q[AW-1:0];
		else if (cmd.em_rd) a0_ra = k_q[AW-1:0];
	end

	esort_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_rec (
		.clk   (clk),
		.we    (cmd.load && (count_q < CW'(DEPTH))),
		.waddr (count_q[AW-1:0]),
		.wdata ({state_label, energy, momentum_x, momentum_y, spin_twice}),
		.raddr (a0_rd[EW-1:EW-AW]),
		.rdata (rec_rd)
	);

	esort_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_a0 (
		.clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a0_ra), .rdata(a0_rd)
	);

	esort_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_a1 (
		.clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(i2_q[AW-1:0]),
		.rdata(a1_rd)
	);

	esort_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_b (
		.clk   (clk),
		.we    (cmd.mrg_cmp),
		.waddr (k_q[AW-1:0]),
		.wdata (take_right ? a1_rd : a0_rd),
		.raddr (k_q[AW-1:0]),
		.rdata (b_rd)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tol_q   <= esort_pkg::TOL_RESET;
			sp_q    <= '0;
		end else begin
			if (cfg_we) tol_q <= cfg_wdata;
			if (cmd.load && (count_q < CW'(DEPTH))) count_q <= CW'(count_q + 1'b1);
			if (cmd.em_out && sts.emit_last) count_q <= '0;
			if (cmd.init) sp_q <= SPW'(1);
			if (cmd.node) begin
				if (top_ph == esort_pkg::PH_MERGE) sp_q <= SPW'(sp_q - 1'b1);
				else if (child_m > CW'(2)) sp_q <= SPW'(sp_q + 1'b1);
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= (count_q < CW'(DEPTH)) ? CW'(count_q + 1'b1) : count_q;
		end
		if (cmd.init) begin
			stk_lo_q[0] <= '0;
			stk_m_q[0]  <= n_q;
			stk_ph_q[0] <= esort_pkg::PH_LEFT;
			pi_q        <= '0;
		end
		if (cmd.node) begin
			if (top_ph == esort_pkg::PH_MERGE) begin
				mlo_q  <= top_lo;
				mid_q  <= CW'(top_lo + half);
				hi_q   <= CW'(top_lo + top_m);
				i1_q   <= top_lo;
				i2_q   <= CW'(top_lo + half);
				k_q    <= top_lo;
				leaf_q <= 1'b0;
			end else begin
				stk_ph_q[top] <= (top_ph == esort_pkg::PH_LEFT) ? esort_pkg::PH_RIGHT
					: esort_pkg::PH_MERGE;
				if (child_m > CW'(2)) begin
					stk_lo_q[sp_q[TW-1:0]] <= child_lo;
					stk_m_q[sp_q[TW-1:0]]  <= child_m;
					stk_ph_q[sp_q[TW-1:0]] <= esort_pkg::PH_LEFT;
				end
				mlo_q  <= child_lo;
				mid_q  <= CW'(child_lo + 1'b1);
				hi_q   <= CW'(child_lo + 2'd2);
				i1_q   <= child_lo;
				i2_q   <= CW'(child_lo + 1'b1);
				k_q    <= child_lo;
				leaf_q <= 1'b1;
			end
		end
		if (cmd.mrg_cmp) begin
			if (take_right) i2_q <= CW'(i2_q + 1'b1);
			else i1_q <= CW'(i1_q + 1'b1);
			k_q <= sts.mrg_last ? mlo_q : CW'(k_q + 1'b1);
		end
		if (cmd.cp_wr) k_q <= CW'(k_q + 1'b1);
		if (cmd.p_base) begin
			rec_i_q <= a0_rd;
			rec_k_q <= a0_rd;
			base_q  <= e1;
			best_q  <= s1;
			pk_q    <= pi_q;
			pj_q    <= pi_q;
		end
		if (cmd.p_dif) begin
			ent_q <= a0_rd;
			mag_q <= d_fwd[EGW] ? d_rev[EGW-1:0] : d_fwd[EGW-1:0];
		end
		if (cmd.p_cmp) begin
			if (!sts.scan_stop && (best_q > sj)) begin
				best_q  <= sj;
				rec_k_q <= ent_q;
				pk_q    <= pj_q;
			end
			pj_q <= CW'(pj_q + 1'b1);
		end
		if (cmd.p_sw2) begin
			pi_q <= CW'(pi_q + 1'b1);
			k_q  <= '0;
		end
		if (cmd.em_rec) final_q <= sts.emit_last;
		if (cmd.em_out) k_q <= CW'(k_q + 1'b1);
	end

	assign {sorted_label, sorted_energy, sorted_momentum_x, sorted_momentum_y,
		sorted_spin_twice} = rec_rd;
	assign final_record = final_q;

endmodule
`default_nettype wire
